FILE: rtl/fcr_pkg.sv
// fcr_pkg: shared types and constants of the fat16 cluster chain reader
// used by fcr_step and fat16_cluster_chain_reader; no dependencies
package fcr_pkg;

	localparam int SECTOR_BYTES_DEF = 512;

	// input function codes
	localparam logic [1:0] FUNC_OPEN_ROOT  = 2'd0;
	localparam logic [1:0] FUNC_OPEN_ENTRY = 2'd1;
	localparam logic [1:0] FUNC_READ       = 2'd2;
	localparam logic [1:0] FUNC_FAT_VALUE  = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_FAT     = 3'd1;
	localparam logic [2:0] KIND_END     = 3'd2;
	localparam logic [2:0] KIND_POS     = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	// register indexes
	localparam logic [1:0] REG_FAT_BASE  = 2'd0;
	localparam logic [1:0] REG_DATA_BASE = 2'd1;
	localparam logic [1:0] REG_SPC       = 2'd2;

	localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
	localparam logic [7:0]  DOT_NAME     = 8'h2E;
	localparam int          DIR_ATTR_BIT = 4;
	localparam logic [31:0] NO_LIMIT     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] start_address;
		logic [31:0] length_bytes;
		logic [15:0] start_cluster;
		logic        is_dir;
		logic [7:0]  request_bytes;
		logic [15:0] next_cluster;
		logic [31:0] cl_prod;
	} fcr_item_t;

	typedef struct packed {
		logic [15:0] current_cluster;
		logic [31:0] cluster_bytes_left;
		logic [31:0] file_bytes_left;
		logic [31:0] position;
		logic [7:0]  pending_bytes;
		logic        awaiting_fat;
	} fcr_state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] address;
		logic [7:0]  byte_count;
	} fcr_result_t;

endpackage

FILE: rtl/fcr_step.sv
// fcr_step: next-state and result logic for one registered item
// depends on fcr_pkg
module fcr_step import fcr_pkg::*; (
	input  fcr_item_t   item,
	input  fcr_state_t  cur,
	input  logic [31:0] fat_base,
	input  logic [31:0] data_base,
	input  logic [31:0] cbl_reload,
	output fcr_state_t  nxt,
	output fcr_result_t res
);

	logic [31:0] caddr;
	logic [31:0] fat_addr;
	logic [31:0] rd_base;
	logic [31:0] rd_cbl;
	logic [7:0]  rd_want;
	logic [7:0]  rd_n;
	logic [31:0] rd_n32;

	// product of (cluster - 2) and cluster size comes from the input stage
	assign caddr    = data_base + item.cl_prod;
	assign fat_addr = fat_base + {15'd0, cur.current_cluster, 1'b0};

	// shared read clamp: a fat value read starts fresh in the new cluster
	assign rd_base = (item.func == FUNC_FAT_VALUE) ? caddr : cur.position;
	assign rd_cbl  = (item.func == FUNC_FAT_VALUE) ? cbl_reload : cur.cluster_bytes_left;
	assign rd_want = (item.func == FUNC_FAT_VALUE) ? cur.pending_bytes : item.request_bytes;

	always_comb begin
		logic [7:0] n;
		n = rd_want;
		if (cur.file_bytes_left < {24'd0, n}) n = cur.file_bytes_left[7:0];
		if (rd_cbl < {24'd0, n}) n = rd_cbl[7:0];
		rd_n = n;
	end

	assign rd_n32 = {24'd0, rd_n};

	always_comb begin
		nxt = cur;
		res = '{kind: KIND_IGNORED, address: 32'd0, byte_count: 8'd0};
		unique case (item.func)
			FUNC_OPEN_ROOT: begin
				nxt.position           = item.start_address;
				nxt.file_bytes_left    = item.length_bytes;
				nxt.cluster_bytes_left = NO_LIMIT;
				nxt.awaiting_fat       = 1'b0;
				nxt.pending_bytes      = 8'd0;
				res = '{kind: KIND_POS, address: item.start_address, byte_count: 8'd0};
			end
			FUNC_OPEN_ENTRY: begin
				nxt.current_cluster    = item.start_cluster;
				nxt.cluster_bytes_left = cbl_reload;
				nxt.file_bytes_left    = item.is_dir ? NO_LIMIT : item.length_bytes;
				nxt.position           = caddr;
				nxt.awaiting_fat       = 1'b0;
				nxt.pending_bytes      = 8'd0;
				res = '{kind: KIND_POS, address: caddr, byte_count: 8'd0};
			end
			FUNC_READ: begin
				if (cur.file_bytes_left == 32'd0) begin
					res.kind = KIND_END;
				end else if (cur.cluster_bytes_left == 32'd0) begin
					nxt.pending_bytes = item.request_bytes;
					nxt.awaiting_fat  = 1'b1;
					res = '{kind: KIND_FAT, address: fat_addr, byte_count: 8'd0};
				end else begin
					nxt.position           = rd_base + rd_n32;
					nxt.file_bytes_left    = cur.file_bytes_left - rd_n32;
					nxt.cluster_bytes_left = rd_cbl - rd_n32;
					res = '{kind: KIND_READ, address: rd_base, byte_count: rd_n};
				end
			end
			FUNC_FAT_VALUE: begin
				if (cur.awaiting_fat) begin
					nxt.awaiting_fat       = 1'b0;
					nxt.pending_bytes      = 8'd0;
					nxt.current_cluster    = item.next_cluster;
					nxt.cluster_bytes_left = cbl_reload;
					if (item.next_cluster == END_OF_CHAIN) begin
						nxt.file_bytes_left = 32'd0;
						res.kind = KIND_END;
					end else begin
						nxt.position           = rd_base + rd_n32;
						nxt.file_bytes_left    = cur.file_bytes_left - rd_n32;
						nxt.cluster_bytes_left = rd_cbl - rd_n32;
						res = '{kind: KIND_READ, address: rd_base, byte_count: rd_n};
					end
				end
			end
			default: begin
				res.kind = KIND_IGNORED;
			end
		endcase
	end

endmodule

FILE: rtl/fat16_cluster_chain_reader.sv
// fat16_cluster_chain_reader: top level, config registers, input and result stages
// depends on fcr_pkg and fcr_step
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   item    | in_valid/in_stall, func .. next_cluster  | in
//   result  | out_valid/out_stall, kind/address/count  | out
//   config  | apb psel/penable/pwrite/paddr/pwdata     | in
//
// from item beat to result: the input stage holds the item and the cluster-size
// product, then the result stage holds the answer and updates the state.
// one item per cycle sustained; a stalled result holds the pipe, in_stall rises
// only when the input stage is full and the result cannot move.
// reset clears the state, the valids and the registers (sectors per cluster to 1).
module fat16_cluster_chain_reader import fcr_pkg::*; #(
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] start_address,
	input  logic [31:0] length_bytes,
	input  logic [15:0] start_cluster,
	input  logic [7:0]  attributes,
	input  logic [7:0]  first_name_byte,
	input  logic [7:0]  request_bytes,
	input  logic [15:0] next_cluster,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] address,
	output logic [7:0]  byte_count
);

	localparam int BPC_W = 8 + $clog2(SECTOR_BYTES + 1);

	logic [31:0] fat_base_q;
	logic [31:0] data_base_q;
	logic [7:0]  spc_q;
	logic [BPC_W-1:0] bpc;
	logic [31:0] cbl_reload;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	fcr_state_t  state_q;
	fcr_state_t  state_nxt;
	fcr_item_t   item_s1;
	logic        valid_s1;
	fcr_result_t res_s2;
	fcr_result_t res_nxt;
	logic        valid_s2;

	logic        advance;
	logic        in_acc;
	logic [15:0] cl_sel;
	logic [31:0] cl_off;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_base_q  <= 32'd0;
			data_base_q <= 32'd0;
			spc_q       <= 8'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FAT_BASE:  fat_base_q  <= pwdata;
				REG_DATA_BASE: data_base_q <= pwdata;
				REG_SPC:       spc_q       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FAT_BASE:  prdata = fat_base_q;
			REG_DATA_BASE: prdata = data_base_q;
			REG_SPC:       prdata = {24'd0, spc_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign bpc        = BPC_W'(spc_q) * BPC_W'(SECTOR_BYTES);
	assign cbl_reload = 32'(bpc);

	// handshake
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	// cluster offset wraps for clusters 0 and 1, as 32-bit arithmetic does
	assign cl_sel = func[1] ? next_cluster : start_cluster;
	assign cl_off = {16'd0, cl_sel} - 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.func          <= func;
			item_s1.start_address <= start_address;
			item_s1.length_bytes  <= length_bytes;
			item_s1.start_cluster <= start_cluster;
			item_s1.is_dir        <= (first_name_byte == DOT_NAME) || attributes[DIR_ATTR_BIT];
			item_s1.request_bytes <= request_bytes;
			item_s1.next_cluster  <= next_cluster;
			item_s1.cl_prod       <= cl_off * cbl_reload;
		end
	end

	fcr_step u_step (
		.item       (item_s1),
		.cur        (state_q),
		.fat_base   (fat_base_q),
		.data_base  (data_base_q),
		.cbl_reload (cbl_reload),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) res_s2 <= res_nxt;
	end

	assign out_valid  = valid_s2;
	assign kind       = res_s2.kind;
	assign address    = res_s2.address;
	assign byte_count = res_s2.byte_count;

`ifndef SYNTHESIS
	a_count_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.byte_count != 8'd0) |-> (res_s2.kind == KIND_READ))
		else $error("byte count set on a non-read result");
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipe");
	a_pending_needs_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.awaiting_fat |-> (state_q.pending_bytes == 8'd0))
		else $error("pending read kept without a fat wait");
	a_fat_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.kind == KIND_FAT) |-> state_q.awaiting_fat)
		else $error("fat fetch shown while not waiting for the fat value");
	a_end_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.kind == KIND_END || res_s2.kind == KIND_IGNORED))
		|-> (res_s2.address == 32'd0))
		else $error("address set on an end or ignored result");
`endif

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for fat16_cluster_chain_reader
// drives item beats and apb register writes, predicts every result beat in-bench
// depends on fcr_pkg and the rtl top level
module tb_top import fcr_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] start_address;
		logic [31:0] length_bytes;
		logic [15:0] start_cluster;
		logic [7:0]  attributes;
		logic [7:0]  first_name_byte;
		logic [7:0]  request_bytes;
		logic [15:0] next_cluster;
	} chain_cmd_t;

	typedef struct packed {
		chain_cmd_t  cmd;
		logic        fixed;
		fcr_result_t answer;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] start_address;
	logic [31:0] length_bytes;
	logic [15:0] start_cluster;
	logic [7:0]  attributes;
	logic [7:0]  first_name_byte;
	logic [7:0]  request_bytes;
	logic [15:0] next_cluster;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [31:0] address;
	logic [7:0]  byte_count;

	fat16_cluster_chain_reader dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .start_address(start_address), .length_bytes(length_bytes),
		.start_cluster(start_cluster), .attributes(attributes),
		.first_name_byte(first_name_byte), .request_bytes(request_bytes),
		.next_cluster(next_cluster),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .address(address), .byte_count(byte_count)
	);

	// predictor copy of the registers and the chain state
	logic [31:0] cfg_fat, cfg_data;
	logic [7:0]  cfg_spc;
	logic [15:0] cur_cl;
	logic [31:0] clus_left, file_rem, pos;
	logic [7:0]  pend;
	logic        wait_fat;

	fcr_result_t answer_q[$];
	script_row_t script[$];
	int errors = 0;
	int cycles = 0;
	int busy_items = 0;
	int burst_left = 0;
	int results_seen = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [31:0] cluster_bytes();
		return {24'b0, cfg_spc} * SECTOR_BYTES_DEF;
	endfunction

	function automatic logic [31:0] cluster_base(logic [15:0] cl);
		return cfg_data + ({16'b0, cl} - 32'd2) * cluster_bytes();
	endfunction

	function automatic fcr_result_t take_bytes(logic [31:0] want);
		fcr_result_t r;
		logic [31:0] n;
		n = want;
		if (n > file_rem)
			n = file_rem;
		if (n > clus_left)
			n = clus_left;
		r.kind = KIND_READ;
		r.address = pos;
		r.byte_count = n[7:0];
		pos = pos + n;
		file_rem = file_rem - n;
		clus_left = clus_left - n;
		return r;
	endfunction

	function automatic fcr_result_t follow_chain(chain_cmd_t c);
		fcr_result_t r;
		logic [7:0] want;
		r = '0;
		case (c.func)
			FUNC_OPEN_ROOT: begin
				pos = c.start_address;
				file_rem = c.length_bytes;
				clus_left = NO_LIMIT;
				wait_fat = 1'b0;
				pend = '0;
				r.kind = KIND_POS;
				r.address = pos;
			end
			FUNC_OPEN_ENTRY: begin
				cur_cl = c.start_cluster;
				clus_left = cluster_bytes();
				if (c.first_name_byte == DOT_NAME || c.attributes[DIR_ATTR_BIT])
					file_rem = NO_LIMIT;
				else
					file_rem = c.length_bytes;
				pos = cluster_base(cur_cl);
				wait_fat = 1'b0;
				pend = '0;
				r.kind = KIND_POS;
				r.address = pos;
			end
			FUNC_READ: begin
				if (file_rem == 0) begin
					r.kind = KIND_END;
				end else if (clus_left == 0) begin
					// cluster used up, the request waits for the fat entry
					pend = c.request_bytes;
					wait_fat = 1'b1;
					r.kind = KIND_FAT;
					r.address = cfg_fat + {15'b0, cur_cl, 1'b0};
				end else begin
					r = take_bytes({24'b0, c.request_bytes});
				end
			end
			FUNC_FAT_VALUE: begin
				if (!wait_fat) begin
					r.kind = KIND_IGNORED;
				end else begin
					want = pend;
					wait_fat = 1'b0;
					pend = '0;
					cur_cl = c.next_cluster;
					clus_left = cluster_bytes();
					if (cur_cl == END_OF_CHAIN) begin
						file_rem = '0;
						r.kind = KIND_END;
					end else begin
						pos = cluster_base(cur_cl);
						r = take_bytes({24'b0, want});
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic chain_cmd_t mk_read(logic [7:0] n);
		chain_cmd_t c = '0;
		c.func = FUNC_READ;
		c.request_bytes = n;
		return c;
	endfunction

	function automatic chain_cmd_t mk_fat(logic [15:0] nc);
		chain_cmd_t c = '0;
		c.func = FUNC_FAT_VALUE;
		c.next_cluster = nc;
		return c;
	endfunction

	function automatic chain_cmd_t mk_root(logic [31:0] a, logic [31:0] len);
		chain_cmd_t c = '0;
		c.func = FUNC_OPEN_ROOT;
		c.start_address = a;
		c.length_bytes = len;
		return c;
	endfunction

	function automatic chain_cmd_t mk_entry(logic [15:0] cl, logic [7:0] attr,
			logic [7:0] first, logic [31:0] len);
		chain_cmd_t c = '0;
		c.func = FUNC_OPEN_ENTRY;
		c.start_cluster = cl;
		c.attributes = attr;
		c.first_name_byte = first;
		c.length_bytes = len;
		return c;
	endfunction

	task automatic add_row(chain_cmd_t c, logic fixed, logic [2:0] k, logic [31:0] a,
			logic [7:0] n);
		script_row_t row;
		row.cmd = c;
		row.fixed = fixed;
		row.answer = {k, a, n};
		script.push_back(row);
	endtask

	// mostly well-formed chains, with the unused fields left random
	function automatic chain_cmd_t random_cmd();
		chain_cmd_t c;
		int pick;
		c.start_address = $urandom;
		c.length_bytes = $urandom;
		c.start_cluster = 16'($urandom);
		c.attributes = 8'($urandom);
		c.first_name_byte = 8'($urandom);
		c.request_bytes = 8'($urandom);
		c.next_cluster = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (wait_fat)
			c.func = pick < 75 ? FUNC_FAT_VALUE : pick < 85 ? FUNC_READ :
				pick < 93 ? FUNC_OPEN_ENTRY : FUNC_OPEN_ROOT;
		else if (file_rem == 0)
			c.func = pick < 50 ? FUNC_OPEN_ENTRY : pick < 75 ? FUNC_OPEN_ROOT :
				pick < 90 ? FUNC_READ : FUNC_FAT_VALUE;
		else
			c.func = pick < 85 ? FUNC_READ : pick < 90 ? FUNC_OPEN_ENTRY :
				pick < 94 ? FUNC_OPEN_ROOT : FUNC_FAT_VALUE;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			c.length_bytes = $urandom_range(0, 4000);
		else if (pick == 6)
			c.length_bytes = NO_LIMIT;
		else if (pick == 7)
			c.length_bytes = $urandom_range(0, 2);
		pick = $urandom_range(0, 9);
		if (pick < 5)
			c.start_cluster = 16'($urandom_range(0, 20));
		else if (pick == 5)
			c.start_cluster = END_OF_CHAIN;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			c.next_cluster = END_OF_CHAIN;
		else if (pick < 6)
			c.next_cluster = 16'($urandom_range(0, 15));
		if ($urandom_range(0, 9) < 7)
			c.attributes[DIR_ATTR_BIT] = 1'b0;
		if ($urandom_range(0, 99) < 15)
			c.first_name_byte = DOT_NAME;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			c.request_bytes = 8'hFF;
		else if (pick == 2)
			c.request_bytes = 8'h00;
		return c;
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_FAT_BASE:  cfg_fat = val;
			REG_DATA_BASE: cfg_data = val;
			REG_SPC:       cfg_spc = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// sender bursts with random gaps, some bursts run straight on
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_cmd(chain_cmd_t c, logic fixed, fcr_result_t fixed_answer);
		fcr_result_t r;
		@(negedge clk);
		in_valid <= 1'b1;
		func <= c.func;
		start_address <= c.start_address;
		length_bytes <= c.length_bytes;
		start_cluster <= c.start_cluster;
		attributes <= c.attributes;
		first_name_byte <= c.first_name_byte;
		request_bytes <= c.request_bytes;
		next_cluster <= c.next_cluster;
		do @(posedge clk); while (in_stall);
		r = follow_chain(c);
		if (r.kind != KIND_IGNORED)
			busy_items++;
		answer_q.push_back(fixed ? fixed_answer : r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
		errors++;
	endtask

	// result side stalls on its own pattern of modes
	int stall_run = 0;
	int stall_mode = 0;
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = stall_mode == 3 ? $urandom_range(1, 12) : $urandom_range(20, 80);
		end
		stall_run--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= $urandom_range(0, 3) == 0;
			2: out_stall <= $urandom_range(0, 9) < 7;
			default: out_stall <= 1'b1;
		endcase
	end

	fcr_result_t want_r;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				report_mismatch("unexpected beat", {29'b0, kind}, '0);
			end else begin
				want_r = answer_q.pop_front();
				if (kind !== want_r.kind)
					report_mismatch("kind", {29'b0, kind}, {29'b0, want_r.kind});
				if (address !== want_r.address)
					report_mismatch("address", address, want_r.address);
				if (byte_count !== want_r.byte_count)
					report_mismatch("byte_count", {24'b0, byte_count}, {24'b0, want_r.byte_count});
			end
			results_seen++;
		end
	end

	initial begin
		int ph;
		logic [7:0] spc;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = '0;
		start_address = '0;
		length_bytes = '0;
		start_cluster = '0;
		attributes = '0;
		first_name_byte = '0;
		request_bytes = '0;
		next_cluster = '0;
		cfg_fat = '0;
		cfg_data = '0;
		cfg_spc = 8'd1;
		cur_cl = '0;
		clus_left = '0;
		file_rem = '0;
		pos = '0;
		pend = '0;
		wait_fat = 1'b0;

		// nothing open yet, then root extremes with wrap, then a two-cluster file
		add_row(mk_read(8'd10), 1'b1, KIND_END, 32'h0, 8'd0);
		add_row(mk_fat(16'h1234), 1'b1, KIND_IGNORED, 32'h0, 8'd0);
		add_row(mk_root(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, KIND_POS, 32'hFFFF_FFFF, 8'd0);
		add_row(mk_read(8'hFF), 1'b1, KIND_READ, 32'hFFFF_FFFF, 8'hFF);
		add_row(mk_read(8'h00), 1'b1, KIND_READ, 32'h0000_00FE, 8'h00);
		add_row(mk_root(32'h0, 32'h0), 1'b1, KIND_POS, 32'h0, 8'd0);
		add_row(mk_read(8'd5), 1'b1, KIND_END, 32'h0, 8'd0);
		add_row(mk_entry(16'd2, 8'h00, 8'h41, 32'd700), 1'b0, '0, '0, '0);
		repeat (3) add_row(mk_read(8'hFF), 1'b0, '0, '0, '0);
		add_row(mk_read(8'd100), 1'b0, '0, '0, '0);
		// second request while the fat entry is still out
		add_row(mk_read(8'd50), 1'b0, '0, '0, '0);
		add_row(mk_fat(16'd3), 1'b0, '0, '0, '0);
		add_row(mk_read(8'hFF), 1'b0, '0, '0, '0);
		add_row(mk_read(8'd1), 1'b1, KIND_END, 32'h0, 8'd0);
		// directory by attribute, then dot entry, low clusters wrap the address
		add_row(mk_entry(16'd0, 8'h10, 8'h00, 32'd0), 1'b0, '0, '0, '0);
		add_row(mk_entry(16'hFFFF, 8'hEF, DOT_NAME, 32'd0), 1'b0, '0, '0, '0);
		add_row(mk_read(8'd200), 1'b0, '0, '0, '0);
		add_row(mk_entry(16'd1, 8'h00, 8'hE5, 32'hFFFF_FFFF), 1'b0, '0, '0, '0);
		repeat (3) add_row(mk_read(8'hFF), 1'b0, '0, '0, '0);
		add_row(mk_read(8'd7), 1'b0, '0, '0, '0);
		add_row(mk_fat(END_OF_CHAIN), 1'b1, KIND_END, 32'h0, 8'd0);
		add_row(mk_read(8'd9), 1'b1, KIND_END, 32'h0, 8'd0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			pace();
			send_cmd(script[i].cmd, script[i].fixed, script[i].answer);
		end
		drain();

		for (ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					// all-ones bases and zero-size clusters, plus a write to no register
					cfg_write(REG_FAT_BASE, 32'hFFFF_FFFF);
					cfg_write(REG_DATA_BASE, 32'hFFFF_FFFF);
					cfg_write(REG_SPC, 32'($urandom) & 32'hFFFF_FF00);
					cfg_write(REG_NONE, $urandom);
				end
				2: begin
					cfg_write(REG_FAT_BASE, 32'h0);
					cfg_write(REG_DATA_BASE, 32'h0);
					cfg_write(REG_SPC, 32'd128);
				end
				3: begin
					cfg_write(REG_FAT_BASE, $urandom);
					cfg_write(REG_DATA_BASE, $urandom);
					cfg_write(REG_SPC, 32'd1);
				end
				default: begin
					spc = $urandom_range(0, 1) ? 8'($urandom_range(1, 4)) :
						8'($urandom_range(1, 128));
					cfg_write(REG_FAT_BASE, $urandom);
					cfg_write(REG_DATA_BASE, $urandom);
					cfg_write(REG_SPC, {24'($urandom), spc});
				end
			endcase
			busy_items = 0;
			while (busy_items < ITEMS_PER_PHASE) begin
				pace();
				send_cmd(random_cmd(), 1'b0, '0);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (answer_q.size() != 0)
			report_mismatch("results missing", answer_q.size(), '0);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
